@@ src/ifdc_pkg.sv @@
// Package for the info frame deframer/checker: register indexes, reset values,
// phase encoding and the result record. No dependencies.
package ifdc_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG     = 3'd0,
    CFG_ESCAPE   = 3'd1,
    CFG_MASK     = 3'd2,
    CFG_ADDRESS  = 3'd3,
    CFG_CTRL_S0  = 3'd4,
    CFG_CTRL_S1  = 3'd5
  } cfg_idx_t;

  localparam logic [7:0] FlagRst    = 8'h7E;
  localparam logic [7:0] EscapeRst  = 8'h7D;
  localparam logic [7:0] MaskRst    = 8'h20;
  localparam logic [7:0] AddressRst = 8'h03;
  localparam logic [7:0] CtrlS0Rst  = 8'h00;
  localparam logic [7:0] CtrlS1Rst  = 8'h40;

  localparam logic KindPayload = 1'b0;
  localparam logic KindReport  = 1'b1;

  typedef enum logic [1:0] {
    REPLY_RR0  = 2'd0,
    REPLY_RR1  = 2'd1,
    REPLY_REJ0 = 2'd2,
    REPLY_REJ1 = 2'd3
  } reply_t;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_FLAG = 6'b000010,
    PH_ADDR = 6'b000100,
    PH_CTRL = 6'b001000,
    PH_HDR  = 6'b010000,
    PH_DATA = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] stuff_mask;
    logic [7:0] address_value;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic       check_good;
    logic       sequence_bit;
    reply_t     reply_code;
  } result_t;

endpackage

@@ src/ifdc_core.sv @@
// Per-byte deframer: header hunt, destuffing, one-byte hold-back and check.
// Depends on ifdc_pkg.
module ifdc_core
  import ifdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic       seq_r, seq_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] chk_r, chk_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_vld_r, held_vld_nxt;

  logic       is_flag;
  logic [7:0] ctrl_exp;
  logic [7:0] dstuf;
  logic       good;

  assign is_flag  = (rx_byte == cfg.flag_value);
  assign ctrl_exp = seq_r ? cfg.control_seq_one : cfg.control_seq_zero;
  assign good     = held_vld_r && (chk_r == 8'd0);

  always_comb begin
    dstuf = rx_byte;
    if (esc_r) begin
      if (rx_byte == (cfg.flag_value ^ cfg.stuff_mask)) begin
        dstuf = cfg.flag_value;
      end else if (rx_byte == (cfg.escape_value ^ cfg.stuff_mask)) begin
        dstuf = cfg.escape_value;
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    seq_nxt      = seq_r;
    esc_nxt      = esc_r;
    chk_nxt      = chk_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    res_valid    = 1'b0;
    res          = '{item_kind: KindPayload, payload_byte: 8'd0, check_good: 1'b0,
                     sequence_bit: seq_r, reply_code: REPLY_RR0};
    unique case (phase_r)
      PH_FLAG: begin
        if (rx_byte == cfg.address_value) begin
          phase_nxt = PH_ADDR;
        end else if (!is_flag) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (rx_byte == cfg.control_seq_zero) begin
          seq_nxt   = 1'b0;
          phase_nxt = PH_CTRL;
        end else if (rx_byte == cfg.control_seq_one) begin
          seq_nxt   = 1'b1;
          phase_nxt = PH_CTRL;
        end else if (is_flag) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (rx_byte == (cfg.address_value ^ ctrl_exp)) begin
          phase_nxt    = PH_HDR;
          esc_nxt      = 1'b0;
          chk_nxt      = 8'd0;
          held_vld_nxt = 1'b0;
          held_nxt     = 8'd0;
        end else if (is_flag) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HDR, PH_DATA: begin
        if (is_flag) begin
          if (phase_r == PH_DATA) begin
            res_valid        = 1'b1;
            res.item_kind    = KindReport;
            res.check_good   = good;
            res.reply_code   = good ? (seq_r ? REPLY_RR0 : REPLY_RR1)
                                    : (seq_r ? REPLY_REJ1 : REPLY_REJ0);
            phase_nxt        = PH_FLAG;
            esc_nxt          = 1'b0;
            held_vld_nxt     = 1'b0;
          end
        end else begin
          phase_nxt = PH_DATA;
          if (rx_byte == cfg.escape_value) begin
            esc_nxt = 1'b1;
          end else begin
            esc_nxt          = 1'b0;
            res_valid        = held_vld_r;
            res.payload_byte = held_r;
            held_nxt         = dstuf;
            held_vld_nxt     = 1'b1;
            chk_nxt          = chk_r ^ dstuf;
          end
        end
      end
      default: begin
        phase_nxt = is_flag ? PH_FLAG : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      seq_r      <= 1'b0;
      esc_r      <= 1'b0;
      chk_r      <= 8'd0;
      held_r     <= 8'd0;
      held_vld_r <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      seq_r      <= seq_nxt;
      esc_r      <= esc_nxt;
      chk_r      <= chk_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

  // escape is only pending inside the data field
  a_esc_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (phase_r == PH_DATA)) else $error("escape pending outside data");
  // a held byte only exists while in the data field
  a_held_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    held_vld_r |-> (phase_r == PH_DATA)) else $error("held byte outside data");
  // a report closes the frame back to the flag phase
  a_report_close: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && res.item_kind == KindReport) |=> (phase_r == PH_FLAG))
    else $error("report did not close frame");

endmodule

@@ src/info_frame_deframer_checker_top.sv @@
// Top level of the info frame deframer/checker: config registers, core and
// a two-entry output stage (output register plus skid). Depends on ifdc_pkg, ifdc_core.
// Results are registered in the output register, or the skid entry while out_* stalls.
// Throughput: one byte per cycle while the skid is empty, so in_tready stays high while
// one result waits. Reset (rst_n low, synchronous) restores default registers and hunt.
module info_frame_deframer_checker_top
  import ifdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [8] check_good,
                                  // [9] sequence_bit, [11:10] reply_code, [15:12] zero
  output logic        out_tuser,  // [0] item_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t    cfg_r;
  logic    in_acc;
  logic    res_valid;
  result_t res;
  result_t out_r, skid_r;
  logic    out_vld_r, skid_vld_r;
  logic    out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{flag_value: FlagRst, escape_value: EscapeRst, stuff_mask: MaskRst,
                 address_value: AddressRst, control_seq_zero: CtrlS0Rst,
                 control_seq_one: CtrlS1Rst};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FLAG:    cfg_r.flag_value       <= cfg_data;
        CFG_ESCAPE:  cfg_r.escape_value     <= cfg_data;
        CFG_MASK:    cfg_r.stuff_mask       <= cfg_data;
        CFG_ADDRESS: cfg_r.address_value    <= cfg_data;
        CFG_CTRL_S0: cfg_r.control_seq_zero <= cfg_data;
        CFG_CTRL_S1: cfg_r.control_seq_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_vld_r && out_tready;

  ifdc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .acc       (in_acc),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_take) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= in_acc && res_valid;
        end
      end else if (in_acc && res_valid) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_take) begin
      out_r <= skid_vld_r ? skid_r : res;
    end
    if (!skid_vld_r) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.item_kind;
  assign out_tdata  = {4'd0, out_r.reply_code, out_r.sequence_bit, out_r.check_good,
                       out_r.payload_byte};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r) else $error("skid full with output empty");
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_tready) |=> (out_vld_r && !skid_vld_r))
    else $error("skid entry not moved forward");
  a_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.item_kind == KindReport) |-> (out_r.payload_byte == 8'd0))
    else $error("report carries payload");
  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.item_kind == KindPayload) |->
      (!out_r.check_good && out_r.reply_code == REPLY_RR0))
    else $error("payload item carries report fields");

endmodule
